// ===== sv/stpdir_pkg.sv =====
// stpdir_pkg: shared types and constants for the step/direction generator
// beat payload structs, command codes and timing limits
// no dependencies
`timescale 1ns / 1ps

package stpdir_pkg;

   // widths
   localparam int unsigned KindWidth = 3;
   localparam int unsigned PosWidth  = 32;
   localparam int unsigned TickWidth = 19;

   // command codes carried in the kind field
   localparam logic [KindWidth-1:0] KIND_TICK    = 3'd0;
   localparam logic [KindWidth-1:0] KIND_MOVE_TO = 3'd1;
   localparam logic [KindWidth-1:0] KIND_MOVE_BY = 3'd2;
   localparam logic [KindWidth-1:0] KIND_STOP    = 3'd3;
   localparam logic [KindWidth-1:0] KIND_SET_POS = 3'd4;
   localparam logic [KindWidth-1:0] KIND_ENABLE  = 3'd5;
   localparam logic [KindWidth-1:0] KIND_DISABLE = 3'd6;

   // timing limits
   localparam logic [TickWidth-1:0] MIN_HALF_PERIOD   = 19'd10;
   localparam logic [TickWidth-1:0] HALF_PERIOD_RESET = 19'd500;

   // request beat
   typedef struct packed {
      logic [KindWidth-1:0]       kind;
      logic signed [PosWidth-1:0] value;
   } req_type;

   // response beat
   typedef struct packed {
      logic                       step_out;
      logic                       dir_out;
      logic                       enable_n;
      logic                       busy_res;
      logic signed [PosWidth-1:0] position;
   } rsp_type;

endpackage

// ===== sv/stpdir_core.sv =====
// stpdir_core: motion state and per-beat state update
// holds position, target, run flag, step level, direction, enable, tick count
// depends on stpdir_pkg
`timescale 1ns / 1ps

module stpdir_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  item_en,
   input  stpdir_pkg::req_type                   item,
   input  logic [stpdir_pkg::TickWidth-1:0]      half_period,
   output stpdir_pkg::rsp_type                   result_in
);

   logic [stpdir_pkg::PosWidth-1:0]  position_ff, position_in;
   logic [stpdir_pkg::PosWidth-1:0]  target_ff, target_in;
   logic                             moving_ff, moving_in;
   logic                             pulse_ff, pulse_in;
   logic                             direction_ff, direction_in;
   logic                             disabled_ff, disabled_in;
   logic [stpdir_pkg::TickWidth-1:0] tick_ff, tick_in;

   logic [stpdir_pkg::TickWidth-1:0] limit;
   logic [stpdir_pkg::TickWidth-1:0] tick_next;
   logic [stpdir_pkg::PosWidth-1:0]  pos_stepped;
   logic [stpdir_pkg::PosWidth-1:0]  dest;
   logic [stpdir_pkg::PosWidth-1:0]  value_u;

   // half period floor, tick count and stepped position
   always_comb begin
      limit       = (half_period < stpdir_pkg::MIN_HALF_PERIOD) ?
                    stpdir_pkg::MIN_HALF_PERIOD : half_period;
      tick_next   = tick_ff + 1'b1;
      pos_stepped = direction_ff ? position_ff + 1'b1 : position_ff - 1'b1;
      value_u     = item.value;
      dest        = (item.kind == stpdir_pkg::KIND_MOVE_TO) ?
                    value_u : position_ff + value_u;
   end

   // next state for one beat
   always_comb begin
      position_in  = position_ff;
      target_in    = target_ff;
      moving_in    = moving_ff;
      pulse_in     = pulse_ff;
      direction_in = direction_ff;
      disabled_in  = disabled_ff;
      tick_in      = tick_ff;
      unique case (item.kind)
         stpdir_pkg::KIND_TICK: begin
            if (moving_ff) begin
               if (tick_next >= limit) begin
                  tick_in = '0;
                  if (!pulse_ff) begin
                     pulse_in = 1'b1;
                  end else begin
                     // falling edge moves one step, arriving ends the run
                     pulse_in    = 1'b0;
                     position_in = pos_stepped;
                     if (pos_stepped == target_ff) begin
                        moving_in = 1'b0;
                     end
                  end
               end else begin
                  tick_in = tick_next;
               end
            end
         end
         stpdir_pkg::KIND_MOVE_TO, stpdir_pkg::KIND_MOVE_BY: begin
            // a move onto the current position changes nothing
            if (dest != position_ff) begin
               moving_in    = 1'b1;
               pulse_in     = 1'b0;
               tick_in      = '0;
               target_in    = dest;
               direction_in = $signed(dest) > $signed(position_ff);
            end
         end
         stpdir_pkg::KIND_STOP: begin
            moving_in = 1'b0;
            pulse_in  = 1'b0;
            tick_in   = '0;
         end
         stpdir_pkg::KIND_SET_POS: begin
            moving_in   = 1'b0;
            pulse_in    = 1'b0;
            tick_in     = '0;
            position_in = value_u;
            target_in   = value_u;
         end
         stpdir_pkg::KIND_ENABLE: begin
            disabled_in = 1'b0;
         end
         stpdir_pkg::KIND_DISABLE: begin
            disabled_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         target_ff    <= '0;
         moving_ff    <= 1'b0;
         pulse_ff     <= 1'b0;
         direction_ff <= 1'b0;
         disabled_ff  <= 1'b1;
         tick_ff      <= '0;
      end else if (item_en) begin
         position_ff  <= position_in;
         target_ff    <= target_in;
         moving_ff    <= moving_in;
         pulse_ff     <= pulse_in;
         direction_ff <= direction_in;
         disabled_ff  <= disabled_in;
         tick_ff      <= tick_in;
      end
   end

   // state after this beat
   always_comb begin
      result_in.step_out = pulse_in;
      result_in.dir_out  = direction_in;
      result_in.enable_n = disabled_in;
      result_in.busy_res = moving_in;
      result_in.position = position_in;
   end

endmodule

// ===== sv/stepper_step_dir_generator.sv =====
// stepper_step_dir_generator: step/direction pulse generator, top level
// input register, half period register and result register around stpdir_core
// depends on stpdir_pkg and stpdir_core
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data (stpdir_pkg::req_type)
//   rsp      out        rsp_valid / rsp_stall  rsp_data (stpdir_pkg::rsp_type)
//   csr      in         csr_valid / csr_ready  csr_data (half period ticks)
//
// one beat per cycle sustained while rsp_stall is low; a taken beat passes its
// input register, the core's motion update and result register to rsp_data
// reset: stopped at position 0, driver disabled, half period 500 ticks
// rsp_stall holds the result register; req_stall rises only when the input
// register is full and the result register cannot be refilled
`timescale 1ns / 1ps

module stepper_step_dir_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  stpdir_pkg::req_type                   req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output stpdir_pkg::rsp_type                   rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [stpdir_pkg::TickWidth-1:0]      csr_data
);

   logic                             in_valid_ff;
   stpdir_pkg::req_type              in_data_ff;
   logic                             out_valid_ff;
   stpdir_pkg::rsp_type              out_data_ff;
   stpdir_pkg::rsp_type              out_data_in;
   logic [stpdir_pkg::TickWidth-1:0] half_period_ff;
   logic                             advance;
   logic                             item_en;

   // pipeline flow
   assign advance   = !out_valid_ff || !rsp_stall;
   assign item_en   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   // half period register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= stpdir_pkg::HALF_PERIOD_RESET;
      end else if (csr_valid) begin
         half_period_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // motion state
   stpdir_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_en     (item_en),
      .item        (in_data_ff),
      .half_period (half_period_ff),
      .result_in   (out_data_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_en) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
